>>> hw/rtl/tree_leaves_level_order_assert.svh
// assertion macros for the tree leaves level order block
// used by the port checker; needs clk and rst in the scope of each use
`ifndef TREE_LEAVES_LEVEL_ORDER_ASSERT_SVH
`define TREE_LEAVES_LEVEL_ORDER_ASSERT_SVH

// same-cycle implication, off during reset
`define TLO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TLO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tlo_pkg.sv
// types and constants for the tree leaves level order block
// no dependencies
`default_nettype none

package tlo_pkg;

  localparam int IDX_W      = 4;
  localparam int NUM_IDX    = 16;
  localparam int ENTRY_W    = 10;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 8;
  localparam int MAX_LEAVES = 8;
  localparam int LEAF_CNT_W = 4;

  // first member in the high bits, so it matches the stream packing
  typedef struct packed {
    logic [IDX_W-1:0] right_index;
    logic             right_present;
    logic [IDX_W-1:0] left_index;
    logic             left_present;
  } entry_t;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_ROOT  = 7'b0000010,
    ST_QRD   = 7'b0000100,
    ST_NRD   = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_ENQR  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/tree_leaves_level_order.sv
// tree leaves level order: loads node records, walks breadth first, streams leaves
// depends on tlo_pkg
//
// input stream: one node record per transfer, nodes numbered in arrival order;
//   s_tlast marks the final record of a tree. records past MAX_NODES are dropped.
// output stream: one leaf index per transfer in level order, m_tlast on the
//   final leaf; at most 8 leaves per tree, none if no root is found.
// loading accepts one record per cycle. after the last record the block finds the
//   root (ST_ROOT), then walks the queue: a queued node is read from the queue
//   (ST_QRD), its record read (ST_NRD) and evaluated (ST_EVAL), plus ST_ENQR when it
//   has two children; a node outside the tree skips ST_EVAL. the queue and child
//   memories have registered reads, which the walk visits one after the other.
//   the final leaf enters the output register in ST_FLUSH once that register is free;
//   s_tready is low from the last record until then, and high again while that leaf waits.
// a stalled receiver holds the output register; the walk stops when it finds a leaf
//   while another leaf is pending, and picks up when the output register frees.
// reset (synchronous, active high) empties the output register and the loaded
//   tree; both memories need no clearing.
`default_nettype none

module tree_leaves_level_order #(
  parameter int MAX_NODES = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // left_present, left_index, right_present, right_index, zero fill
  input  wire  [tlo_pkg::S_DATA_W-1:0] s_tdata,
  input  wire                          s_tlast,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // leaf_index, zero fill
  output logic [tlo_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);

  import tlo_pkg::*;

  localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] loaded, loaded_next;
  logic [NUM_IDX-1:0] ref_mask, ref_mask_next;
  logic [CNT_W-1:0] head, head_next, tail, tail_next;
  logic [LEAF_CNT_W-1:0] leaf_cnt, leaf_cnt_next;
  logic pend_valid, pend_valid_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;
  logic m_tvalid_next, m_tlast_next;
  logic [M_DATA_W-1:0] m_tdata_next;

  entry_t child_mem [MAX_NODES];
  logic c_we, c_re;
  logic [ADDR_W-1:0] c_waddr, c_raddr;
  entry_t c_wdata, c_rdata;

  logic [IDX_W-1:0] queue_mem [MAX_NODES];
  logic q_we, q_re;
  logic [ADDR_W-1:0] q_waddr, q_raddr;
  logic [IDX_W-1:0] q_wdata, q_rdata;

  entry_t in_rec;
  logic out_free, lv, rv, node_ok, root_found, root_big;
  logic [IDX_W-1:0] root_idx;

  assign in_rec   = entry_t'(s_tdata[ENTRY_W-1:0]);
  assign s_tready = (state == ST_LOAD);
  assign out_free = !m_tvalid || m_tready;
  assign lv       = c_rdata.left_present && (32'(c_rdata.left_index) < 32'(loaded));
  assign rv       = c_rdata.right_present && (32'(c_rdata.right_index) < 32'(loaded));
  assign node_ok  = 32'(q_rdata) < 32'(loaded);
  assign root_big = 32'(loaded) > NUM_IDX;

  // lowest loaded node that no loaded record names as a child
  always_comb begin
    root_found = 1'b0;
    root_idx   = '0;
    for (int i = NUM_IDX - 1; i >= 0; i--) begin
      if (!ref_mask[i] && (i < 32'(loaded))) begin
        root_found = 1'b1;
        root_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    loaded_next     = loaded;
    ref_mask_next   = ref_mask;
    head_next       = head;
    tail_next       = tail;
    leaf_cnt_next   = leaf_cnt;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tlast_next    = m_tlast;
    c_we    = 1'b0;
    c_waddr = loaded[ADDR_W-1:0];
    c_wdata = in_rec;
    c_re    = 1'b0;
    c_raddr = ADDR_W'(q_rdata);
    q_we    = 1'b0;
    q_waddr = tail[ADDR_W-1:0];
    q_wdata = c_rdata.left_index;
    q_re    = 1'b0;
    q_raddr = head[ADDR_W-1:0];

    case (state)
      ST_LOAD: begin
        if (s_tvalid) begin
          if (32'(loaded) < MAX_NODES) begin
            c_we        = 1'b1;
            loaded_next = loaded + CNT_W'(1);
            if (in_rec.left_present) begin
              ref_mask_next = ref_mask_next | (NUM_IDX'(1) << in_rec.left_index);
            end
            if (in_rec.right_present) begin
              ref_mask_next = ref_mask_next | (NUM_IDX'(1) << in_rec.right_index);
            end
          end
          if (s_tlast) begin
            state_next = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (root_found || root_big) begin
          q_we       = 1'b1;
          q_waddr    = '0;
          q_wdata    = root_found ? root_idx : '0;
          head_next  = '0;
          tail_next  = CNT_W'(1);
          state_next = ST_QRD;
        end else begin
          loaded_next   = '0;
          ref_mask_next = '0;
          head_next     = '0;
          tail_next     = '0;
          state_next    = ST_LOAD;
        end
      end
      ST_QRD: begin
        q_re       = 1'b1;
        head_next  = head + CNT_W'(1);
        state_next = ST_NRD;
      end
      ST_NRD: begin
        if (node_ok) begin
          c_re       = 1'b1;
          state_next = ST_EVAL;
        end else begin
          state_next = (head < tail) ? ST_QRD : ST_FLUSH;
        end
      end
      ST_EVAL: begin
        if (lv || rv) begin
          if (32'(tail) < MAX_NODES) begin
            q_we      = 1'b1;
            q_wdata   = lv ? c_rdata.left_index : c_rdata.right_index;
            tail_next = tail + CNT_W'(1);
          end
          if (lv && rv) begin
            state_next = ST_ENQR;
          end else begin
            state_next = (head < tail_next) ? ST_QRD : ST_FLUSH;
          end
        end else if (!pend_valid || out_free) begin
          if (pend_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'(pend_idx);
            m_tlast_next  = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_idx_next   = q_rdata;
          leaf_cnt_next   = leaf_cnt + LEAF_CNT_W'(1);
          if (leaf_cnt_next == LEAF_CNT_W'(MAX_LEAVES) || !(head < tail)) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_QRD;
          end
        end
      end
      ST_ENQR: begin
        if (32'(tail) < MAX_NODES) begin
          q_we      = 1'b1;
          q_wdata   = c_rdata.right_index;
          tail_next = tail + CNT_W'(1);
        end
        state_next = (head < tail_next) ? ST_QRD : ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'(pend_idx);
            m_tlast_next  = 1'b1;
          end
          pend_valid_next = 1'b0;
          leaf_cnt_next   = '0;
          loaded_next     = '0;
          ref_mask_next   = '0;
          head_next       = '0;
          tail_next       = '0;
          state_next      = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      loaded     <= '0;
      ref_mask   <= '0;
      head       <= '0;
      tail       <= '0;
      leaf_cnt   <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      loaded     <= loaded_next;
      ref_mask   <= ref_mask_next;
      head       <= head_next;
      tail       <= tail_next;
      leaf_cnt   <= leaf_cnt_next;
      pend_valid <= pend_valid_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    m_tdata  <= m_tdata_next;
    m_tlast  <= m_tlast_next;
  end

  // child record memory
  always_ff @(posedge clk) begin
    if (c_we) begin
      child_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rdata <= child_mem[c_raddr];
    end
  end

  // breadth-first queue memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata <= queue_mem[q_raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tlo_checker.sv
// port checker for the tree leaves level order block, bound to the top level
// depends on tlo_pkg and tree_leaves_level_order_assert.svh
`default_nettype none

`include "tree_leaves_level_order_assert.svh"

module tlo_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire  [tlo_pkg::S_DATA_W-1:0] s_tdata,
  input wire                          s_tlast,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire  [tlo_pkg::M_DATA_W-1:0] m_tdata,
  input wire                          m_tlast
);

  import tlo_pkg::*;

  logic s_xfer;
  assign s_xfer = s_tvalid && s_tready && (s_tdata[S_DATA_W-1] || !s_tdata[S_DATA_W-1]);

  // stalled leaf holds
  `TLO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
  // the walk starts right after the last record
  `TLO_ASSERT_NEXT(a_walk_start, s_xfer && s_tlast, !s_tready, "input taken during walk")
  // a leaf that is not final can only show while the walk runs
  `TLO_ASSERT_NOW(a_mid_walk, m_tvalid && !m_tlast, !s_tready, "input ready with leaves pending")
  // after reset the block is empty and ready
  `TLO_ASSERT_NOW(a_reset_idle, $past(rst), s_tready && !m_tvalid, "not idle after reset")

endmodule

bind tree_leaves_level_order tlo_checker u_tlo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// testbench for tree_leaves_level_order: node records in, leaf indices out in level order
// predicts each tree's leaves from the accepted records and checks every output transfer
// depends on tlo_pkg and tree_leaves_level_order

module tb;
  import tlo_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_RECORDS = 195;

  typedef struct {
    entry_t fields;
    bit     tree_end;
    bit     hold;
  } node_rec_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic             final_leaf;
  } leaf_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  node_rec_t record_q[$];
  leaf_t     pending_leaves[$];

  entry_t      node_tab[NUM_IDX];
  int unsigned nodes_held = 0;

  node_rec_t tx_cur;
  bit        tx_busy;
  bit        tx_burst = 1'b0;
  int        tx_gap = 0;
  int        leaves_due = 0;
  int        leaves_seen = 0;
  bit        rx_burst = 1'b0;
  int        rx_wait = 0;
  leaf_t     want;
  int        mismatches = 0;
  int        quiet = 0;
  int        directed_count;

  tree_leaves_level_order dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic entry_t node_fields(bit lp, int li, bit rp, int ri);
    entry_t e;
    e.left_present  = lp;
    e.left_index    = li[IDX_W-1:0];
    e.right_present = rp;
    e.right_index   = ri[IDX_W-1:0];
    return e;
  endfunction

  task automatic put_record(entry_t f, bit tree_end, bit hold);
    node_rec_t r;
    r.fields   = f;
    r.tree_end = tree_end;
    r.hold     = hold;
    record_q.push_back(r);
  endtask

  // well-formed tree of n records with shuffled numbering; past NUM_IDX the records are noise
  task automatic queue_random_tree(int n, bit hold);
    int lch[NUM_IDX];
    int rch[NUM_IDX];
    int label[NUM_IDX];
    entry_t shape[NUM_IDX];
    logic [ENTRY_W-1:0] raw;
    int m, k, p, j, t;
    bit placed;
    m = (n > NUM_IDX) ? NUM_IDX : n;
    for (k = 0; k < m; k++) begin
      lch[k] = -1;
      rch[k] = -1;
      label[k] = k;
    end
    for (k = 1; k < m; k++) begin
      placed = 1'b0;
      while (!placed) begin
        p = $urandom_range(0, k - 1);
        if ($urandom_range(0, 1) == 1) begin
          if (lch[p] < 0) begin
            lch[p] = k;
            placed = 1'b1;
          end
        end else if (rch[p] < 0) begin
          rch[p] = k;
          placed = 1'b1;
        end
      end
    end
    for (k = m - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = label[k];
      label[k] = label[j];
      label[j] = t;
    end
    for (k = 0; k < m; k++) begin
      shape[label[k]] = node_fields(lch[k] >= 0,
                                    (lch[k] >= 0) ? label[lch[k]] : $urandom_range(0, 15),
                                    rch[k] >= 0,
                                    (rch[k] >= 0) ? label[rch[k]] : $urandom_range(0, 15));
    end
    for (k = 0; k < m; k++) put_record(shape[k], n == m && k == m - 1, hold && k == 0);
    for (k = m; k < n; k++) begin
      raw = $urandom;
      put_record(raw, k == n - 1, 1'b0);
    end
  endtask

  // takes one accepted record; on the tree end walks the tree and queues its leaves
  function automatic int absorb_record(entry_t e, bit tree_end);
    logic [NUM_IDX-1:0] has_parent;
    logic [IDX_W-1:0]   bfs[NUM_IDX];
    int unsigned        root, head, tail, n;
    int                 leaves;
    entry_t             cur;
    bit                 lv, rv;
    leaf_t              x;
    if (nodes_held < NUM_IDX) begin
      node_tab[nodes_held] = e;
      nodes_held++;
    end
    if (!tree_end) return 0;
    has_parent = '0;
    for (n = 0; n < nodes_held; n++) begin
      cur = node_tab[n];
      if (cur.left_present && cur.left_index < nodes_held) has_parent[cur.left_index] = 1'b1;
      if (cur.right_present && cur.right_index < nodes_held) has_parent[cur.right_index] = 1'b1;
    end
    root = nodes_held;
    for (n = 0; n < nodes_held; n++) begin
      if (root == nodes_held && !has_parent[n]) root = n;
    end
    leaves = 0;
    if (root < nodes_held) begin
      bfs[0] = root[IDX_W-1:0];
      head = 0;
      tail = 1;
      while (head < tail) begin
        cur = node_tab[bfs[head]];
        x.index = bfs[head];
        x.final_leaf = 1'b0;
        head++;
        lv = cur.left_present && cur.left_index < nodes_held;
        rv = cur.right_present && cur.right_index < nodes_held;
        if (lv && tail < NUM_IDX) begin
          bfs[tail] = cur.left_index;
          tail++;
        end
        if (rv && tail < NUM_IDX) begin
          bfs[tail] = cur.right_index;
          tail++;
        end
        if (!lv && !rv && leaves < MAX_LEAVES) begin
          pending_leaves.push_back(x);
          leaves++;
        end
      end
      if (leaves > 0) pending_leaves[pending_leaves.size() - 1].final_leaf = 1'b1;
    end
    nodes_held = 0;
    return leaves;
  endfunction

  task automatic note_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // record driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      tx_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        leaves_due += absorb_record(tx_cur.fields, tx_cur.tree_end);
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (record_q.size() != 0 && !(record_q[0].hold && leaves_due != leaves_seen)) begin
          tx_cur = record_q.pop_front();
          s_tdata <= S_DATA_W'(tx_cur.fields);
          s_tlast <= tx_cur.tree_end;
          tx_busy = 1'b1;
          if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
        end
      end
      s_tvalid <= tx_busy;
    end
  end

  // leaf monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        leaves_seen <= leaves_seen + 1;
        if (pending_leaves.size() == 0) begin
          note_mismatch($sformatf("leaf %0d with none expected", m_tdata[IDX_W-1:0]));
        end else begin
          want = pending_leaves.pop_front();
          if (m_tdata[IDX_W-1:0] !== want.index)
            note_mismatch($sformatf("leaf index %0d, expected %0d",
                                    m_tdata[IDX_W-1:0], want.index));
          if (m_tlast !== want.final_leaf)
            note_mismatch($sformatf("final marker %b on leaf %0d, expected %b",
                                    m_tlast, want.index, want.final_leaf));
        end
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int k, n, pick;
    // single node whose children both lie outside the tree
    put_record(node_fields(1, 15, 1, 15), 1'b1, 1'b0);
    // two nodes pointing at each other: no root, no leaves
    put_record(node_fields(1, 1, 0, 0), 1'b0, 1'b0);
    put_record(node_fields(0, 15, 1, 0), 1'b1, 1'b0);
    // shared children fill the walk queue
    put_record(node_fields(1, 1, 1, 1), 1'b0, 1'b0);
    put_record(node_fields(1, 2, 1, 2), 1'b0, 1'b0);
    put_record(node_fields(1, 3, 1, 3), 1'b0, 1'b0);
    put_record(node_fields(1, 4, 1, 4), 1'b0, 1'b0);
    put_record(node_fields(0, 15, 0, 15), 1'b1, 1'b0);
    // complete tree of sixteen nodes, eight leaves, then a dropped record ends it
    for (k = 0; k < NUM_IDX; k++) begin
      put_record(node_fields(2 * k + 1 < NUM_IDX,
                             (2 * k + 1 < NUM_IDX) ? 2 * k + 1 : $urandom_range(0, 15),
                             2 * k + 2 < NUM_IDX,
                             (2 * k + 2 < NUM_IDX) ? 2 * k + 2 : $urandom_range(0, 15)),
                 1'b0, k == 0);
    end
    put_record(node_fields(1, 0, 1, 0), 1'b1, 1'b0);
    directed_count = record_q.size();

    while (record_q.size() < directed_count + RANDOM_RECORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        n = (pick < 8) ? $urandom_range(9, 18) : $urandom_range(1, 8);
        queue_random_tree(n, record_q.size() == directed_count || $urandom_range(0, 19) == 0);
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          put_record(node_fields($urandom_range(0, 1),
                                 $urandom_range(0, 1) ? $urandom_range(0, n) : $urandom_range(0, 15),
                                 $urandom_range(0, 1),
                                 $urandom_range(0, 1) ? $urandom_range(0, n) : $urandom_range(0, 15)),
                     k == n - 1, 1'b0);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (record_q.size() != 0 || s_tvalid || pending_leaves.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
